@@ hw/rtl/sclie_pkg.sv @@
// ----------------------------------------------------------------------------
// sclie_pkg
// Shared types, constants and register codes for the stream context table
// with least-recently-used replacement and idle eviction.
// ----------------------------------------------------------------------------
package sclie_pkg;

  // Default sizing
  localparam int ENTRIES_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int KEY_W      = 64;
  localparam int NOW_W      = 32;
  localparam int REG_W      = 32;
  localparam int MINS_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int CNT_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_SET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_EVICT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STREAMS = 2'd3;

  // Register reset values
  localparam logic              PATH_SET_RST    = 1'b0;
  localparam logic [REG_W-1:0]  IDLE_EVICT_RST  = 32'd30000;
  localparam logic [REG_W-1:0]  ACTIVE_WIN_RST  = 32'd2000;
  localparam logic [MINS_W-1:0] MIN_STREAMS_RST = 4'd2;

  // Request function codes
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic              path_set;
    logic [REG_W-1:0]  idle_evict_ms;
    logic [REG_W-1:0]  active_window_ms;
    logic [MINS_W-1:0] min_streams;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_AGE,
    ST_CHECK,
    ST_CAP,
    ST_TRIM
  } state_t;

endpackage

@@ hw/rtl/sclie_cfg.sv @@
// ----------------------------------------------------------------------------
// sclie_cfg
// Configuration register file: decodes indexed writes into the settings.
// ----------------------------------------------------------------------------
module sclie_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sclie_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sclie_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sclie_pkg::cfg_t                    cfg
);

  sclie_pkg::cfg_t cfg_r;

  // Always take a write request
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode and store register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.path_set         <= sclie_pkg::PATH_SET_RST;
      cfg_r.idle_evict_ms    <= sclie_pkg::IDLE_EVICT_RST;
      cfg_r.active_window_ms <= sclie_pkg::ACTIVE_WIN_RST;
      cfg_r.min_streams      <= sclie_pkg::MIN_STREAMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sclie_pkg::CFG_PATH_SET:    cfg_r.path_set         <= cfg_data[0];
        sclie_pkg::CFG_IDLE_EVICT:  cfg_r.idle_evict_ms    <= cfg_data[sclie_pkg::REG_W-1:0];
        sclie_pkg::CFG_ACTIVE_WIN:  cfg_r.active_window_ms <= cfg_data[sclie_pkg::REG_W-1:0];
        sclie_pkg::CFG_MIN_STREAMS: cfg_r.min_streams      <= cfg_data[sclie_pkg::MINS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sclie_mem.sv @@
// ----------------------------------------------------------------------------
// sclie_mem
// Entry store: stream keys and last-use times, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module sclie_mem #(
  parameter int ENTRIES   = sclie_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = sclie_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = $clog2(ENTRIES)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [IDX_W-1:0]              waddr,
  input  logic [sclie_pkg::KEY_W-1:0]   wkey,
  input  logic [TIME_BITS-1:0]          wtime,
  input  logic [IDX_W-1:0]              raddr,
  output logic [sclie_pkg::KEY_W-1:0]   rkey,
  output logic [TIME_BITS-1:0]          rtime
);

  logic [sclie_pkg::KEY_W-1:0] key_mem  [ENTRIES];
  logic [TIME_BITS-1:0]        time_mem [ENTRIES];
  logic [sclie_pkg::KEY_W-1:0] rkey_r;
  logic [TIME_BITS-1:0]        rtime_r;

  // Write key and time together
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      time_mem[waddr] <= wtime;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rkey_r  <= key_mem[raddr];
    rtime_r <= time_mem[raddr];
  end

  assign rkey  = rkey_r;
  assign rtime = rtime_r;

endmodule

@@ hw/rtl/sclie_ctrl.sv @@
// ----------------------------------------------------------------------------
// sclie_ctrl
// Sequencer: sweeps the entry store for lookup, idle eviction and LRU
// trimming, holds the valid bits and builds the result.
// ----------------------------------------------------------------------------
module sclie_ctrl #(
  parameter int ENTRIES   = sclie_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = sclie_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = $clog2(ENTRIES)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sclie_pkg::cfg_t                     cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [sclie_pkg::KEY_W-1:0]         in_stream_id,
  input  logic [sclie_pkg::NOW_W-1:0]         in_now_ms,
  input  logic                                in_open_ok,
  output logic                                mem_we,
  output logic [IDX_W-1:0]                    mem_waddr,
  output logic [sclie_pkg::KEY_W-1:0]         mem_wkey,
  output logic [TIME_BITS-1:0]                mem_wtime,
  output logic [IDX_W-1:0]                    mem_raddr,
  input  logic [sclie_pkg::KEY_W-1:0]         mem_rkey,
  input  logic [TIME_BITS-1:0]                mem_rtime,
  output logic                                out_valid,
  output logic                                out_found,
  output logic                                out_was_hit,
  output logic [sclie_pkg::SLOT_W-1:0]        out_slot,
  output logic [sclie_pkg::CNT_OUT_W-1:0]     out_shares,
  output logic [sclie_pkg::CNT_OUT_W-1:0]     out_evicted
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > sclie_pkg::REG_W) ? TIME_BITS : sclie_pkg::REG_W;
  localparam int CAP_W = (CNT_W + 1 > sclie_pkg::MINS_W) ? CNT_W + 1 : sclie_pkg::MINS_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

  sclie_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [IDX_W-1:0]              pidx_r, pidx_nxt;
  logic                          pvld_r, pvld_nxt;
  logic [ENTRIES-1:0]            valid_r, valid_nxt;
  logic [sclie_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [TIME_BITS-1:0]          now_r, now_nxt;
  logic                          ok_r, ok_nxt;
  logic                          hit_r, hit_nxt;
  logic [IDX_W-1:0]              hit_idx_r, hit_idx_nxt;
  logic                          free_r, free_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic                          lru_any_r, lru_any_nxt;
  logic [IDX_W-1:0]              lru_idx_r, lru_idx_nxt;
  logic [TIME_BITS-1:0]          lru_idle_r, lru_idle_nxt;
  logic [CNT_W-1:0]              nvalid_r, nvalid_nxt;
  logic [IDX_W-1:0]              cur_r, cur_nxt;
  logic [CNT_W-1:0]              drop_r, drop_nxt;
  logic [CNT_W-1:0]              active_r, active_nxt;
  logic [CNT_W-1:0]              size_r, size_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [sclie_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [sclie_pkg::CNT_OUT_W-1:0] out_shares_r, out_shares_nxt;
  logic [sclie_pkg::CNT_OUT_W-1:0] out_evicted_r, out_evicted_nxt;

  logic [TIME_BITS-1:0]          idle;
  logic [CMP_W-1:0]              idle_ext, evict_ext, win_ext;
  logic [CAP_W-1:0]              act_plus, min_cap, cap, size_ext;
  logic                          over_cap;
  logic                          sweep_end;
  logic                          finish;
  logic [IDX_W-1:0]              cur_sel;

  // Idle time of the entry whose data is arriving
  assign idle      = now_r - mem_rtime;
  assign idle_ext  = CMP_W'(idle);
  assign evict_ext = CMP_W'(cfg.idle_evict_ms);
  assign win_ext   = CMP_W'(cfg.active_window_ms);

  // Entry cap: max(min streams, active + 1)
  assign act_plus = CAP_W'(active_r) + CAP_W'(1);
  assign min_cap  = CAP_W'(cfg.min_streams);
  assign cap      = (min_cap > act_plus) ? min_cap : act_plus;
  assign size_ext = CAP_W'(size_r);
  assign over_cap = size_ext > cap;

  assign sweep_end = (cnt_r == LAST_CNT);
  assign mem_raddr = cnt_r[IDX_W-1:0];
  assign busy      = (state_r != sclie_pkg::ST_IDLE);

  // Pick the slot for this access
  always_comb begin
    if (hit_r)       cur_sel = hit_idx_r;
    else if (free_r) cur_sel = free_idx_r;
    else             cur_sel = lru_idx_r;
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclie_pkg::ST_IDLE;
      cnt_r       <= '0;
      pvld_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pvld_r      <= pvld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r        <= pidx_nxt;
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    ok_r          <= ok_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    lru_any_r     <= lru_any_nxt;
    lru_idx_r     <= lru_idx_nxt;
    lru_idle_r    <= lru_idle_nxt;
    nvalid_r      <= nvalid_nxt;
    cur_r         <= cur_nxt;
    drop_r        <= drop_nxt;
    active_r      <= active_nxt;
    size_r        <= size_nxt;
    out_found_r   <= out_found_nxt;
    out_hit_r     <= out_hit_nxt;
    out_slot_r    <= out_slot_nxt;
    out_shares_r  <= out_shares_nxt;
    out_evicted_r <= out_evicted_nxt;
  end

  // Next state and sweep processing
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pidx_nxt        = cnt_r[IDX_W-1:0];
    pvld_nxt        = 1'b0;
    valid_nxt       = valid_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    ok_nxt          = ok_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    lru_any_nxt     = lru_any_r;
    lru_idx_nxt     = lru_idx_r;
    lru_idle_nxt    = lru_idle_r;
    nvalid_nxt      = nvalid_r;
    cur_nxt         = cur_r;
    drop_nxt        = drop_r;
    active_nxt      = active_r;
    size_nxt        = size_r;
    mem_we          = 1'b0;
    mem_waddr       = cur_sel;
    mem_wkey        = key_r;
    mem_wtime       = now_r;
    out_valid_nxt   = 1'b0;
    out_found_nxt   = out_found_r;
    out_hit_nxt     = out_hit_r;
    out_slot_nxt    = out_slot_r;
    out_shares_nxt  = out_shares_r;
    out_evicted_nxt = out_evicted_r;
    finish          = 1'b0;

    unique case (state_r)
      sclie_pkg::ST_IDLE: begin
        if (start) begin
          if (in_func == sclie_pkg::FUNC_CLEAR) begin
            // Drop every entry and return an empty result
            valid_nxt       = '0;
            out_valid_nxt   = 1'b1;
            out_found_nxt   = 1'b0;
            out_hit_nxt     = 1'b0;
            out_slot_nxt    = '0;
            out_shares_nxt  = '0;
            out_evicted_nxt = '0;
          end else begin
            // Latch the request and start the lookup sweep
            key_nxt     = in_stream_id;
            now_nxt     = TIME_BITS'(in_now_ms);
            ok_nxt      = in_open_ok;
            hit_nxt     = 1'b0;
            free_nxt    = 1'b0;
            lru_any_nxt = 1'b0;
            nvalid_nxt  = '0;
            cnt_nxt     = '0;
            state_nxt   = sclie_pkg::ST_LOOK;
          end
        end
      end

      sclie_pkg::ST_LOOK: begin
        // Issue the next read
        if (!sweep_end) begin
          pvld_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        // Match key, track first free slot and overall LRU
        if (pvld_r) begin
          if (valid_r[pidx_r]) begin
            nvalid_nxt = nvalid_r + CNT_W'(1);
            if (!hit_r && mem_rkey == key_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = pidx_r;
            end
            if (!lru_any_r || idle > lru_idle_r) begin
              lru_any_nxt  = 1'b1;
              lru_idx_nxt  = pidx_r;
              lru_idle_nxt = idle;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
        end
        if (sweep_end) state_nxt = sclie_pkg::ST_DECIDE;
      end

      sclie_pkg::ST_DECIDE: begin
        if (!hit_r && !(cfg.path_set && ok_r)) begin
          // Failed open: report the current count only
          out_valid_nxt   = 1'b1;
          out_found_nxt   = 1'b0;
          out_hit_nxt     = 1'b0;
          out_slot_nxt    = '0;
          out_shares_nxt  = sclie_pkg::CNT_OUT_W'(nvalid_r);
          out_evicted_nxt = '0;
          state_nxt       = sclie_pkg::ST_IDLE;
        end else begin
          // Write key and time, replacing the LRU entry on a full table
          mem_we             = 1'b1;
          valid_nxt[cur_sel] = 1'b1;
          cur_nxt            = cur_sel;
          drop_nxt           = (!hit_r && !free_r) ? CNT_W'(1) : '0;
          active_nxt         = '0;
          size_nxt           = '0;
          cnt_nxt            = '0;
          state_nxt          = sclie_pkg::ST_AGE;
        end
      end

      sclie_pkg::ST_AGE: begin
        if (!sweep_end) begin
          pvld_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        // Drop idle entries, count survivors and active ones
        if (pvld_r && valid_r[pidx_r]) begin
          if (pidx_r != cur_r && idle_ext >= evict_ext) begin
            valid_nxt[pidx_r] = 1'b0;
            drop_nxt          = drop_r + CNT_W'(1);
          end else begin
            size_nxt = size_r + CNT_W'(1);
            if (idle_ext < win_ext) active_nxt = active_r + CNT_W'(1);
          end
        end
        if (sweep_end) state_nxt = sclie_pkg::ST_CHECK;
      end

      sclie_pkg::ST_CHECK: begin
        if (over_cap) begin
          lru_any_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = sclie_pkg::ST_CAP;
        end else begin
          finish = 1'b1;
        end
      end

      sclie_pkg::ST_CAP: begin
        if (!sweep_end) begin
          pvld_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        // Find the LRU entry other than the accessed one
        if (pvld_r && valid_r[pidx_r] && pidx_r != cur_r) begin
          if (!lru_any_r || idle > lru_idle_r) begin
            lru_any_nxt  = 1'b1;
            lru_idx_nxt  = pidx_r;
            lru_idle_nxt = idle;
          end
        end
        if (sweep_end) state_nxt = sclie_pkg::ST_TRIM;
      end

      sclie_pkg::ST_TRIM: begin
        if (lru_any_r) begin
          valid_nxt[lru_idx_r] = 1'b0;
          drop_nxt             = drop_r + CNT_W'(1);
          size_nxt             = size_r - CNT_W'(1);
          state_nxt            = sclie_pkg::ST_CHECK;
        end else begin
          finish = 1'b1;
        end
      end

      default: state_nxt = sclie_pkg::ST_IDLE;
    endcase

    // Post the result of a completed access
    if (finish) begin
      out_valid_nxt   = 1'b1;
      out_found_nxt   = 1'b1;
      out_hit_nxt     = hit_r;
      out_slot_nxt    = sclie_pkg::SLOT_W'(cur_r);
      out_shares_nxt  = sclie_pkg::CNT_OUT_W'(size_r);
      out_evicted_nxt = sclie_pkg::CNT_OUT_W'(drop_r);
      state_nxt       = sclie_pkg::ST_IDLE;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_was_hit = out_hit_r;
  assign out_slot    = out_slot_r;
  assign out_shares  = out_shares_r;
  assign out_evicted = out_evicted_r;

endmodule

@@ hw/rtl/stream_context_lru_idle_evict.sv @@
// Sequence: a clear returns its result in the cycle after start; a failed miss ends after
//   the lookup sweep, any other access adds the age sweep and a cap sweep per trimmed entry.
// Throughput: one request at a time; busy drops as the result is strobed, so the next
//   request can be taken in that cycle. Every sweep reads the entry store once per cycle.
// Reset: synchronous active-low rst_n empties the table and loads register
//   defaults; no clearing pass. Results are strobed; the receiver cannot stall.
// ----------------------------------------------------------------------------
// stream_context_lru_idle_evict
// Stream context table keyed by stream id with LRU replacement, idle eviction
// and an entry cap driven by the number of active streams.
// ----------------------------------------------------------------------------
module stream_context_lru_idle_evict #(
  parameter int ENTRIES   = sclie_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = sclie_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [sclie_pkg::KEY_W-1:0]         in_stream_id,
  input  logic [sclie_pkg::NOW_W-1:0]         in_now_ms,
  input  logic                                in_open_ok,
  output logic                                out_valid,
  output logic                                out_found,
  output logic                                out_was_hit,
  output logic [sclie_pkg::SLOT_W-1:0]        out_slot,
  output logic [sclie_pkg::CNT_OUT_W-1:0]     out_shares,
  output logic [sclie_pkg::CNT_OUT_W-1:0]     out_evicted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sclie_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sclie_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);

  sclie_pkg::cfg_t             cfg;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [sclie_pkg::KEY_W-1:0] mem_wkey;
  logic [TIME_BITS-1:0]        mem_wtime;
  logic [IDX_W-1:0]            mem_raddr;
  logic [sclie_pkg::KEY_W-1:0] mem_rkey;
  logic [TIME_BITS-1:0]        mem_rtime;

  // Configuration registers
  sclie_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Key and last-use store
  sclie_mem #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wtime (mem_wtime),
    .raddr (mem_raddr),
    .rkey  (mem_rkey),
    .rtime (mem_rtime)
  );

  // Sweep sequencer
  sclie_ctrl #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_stream_id (in_stream_id),
    .in_now_ms    (in_now_ms),
    .in_open_ok   (in_open_ok),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wkey     (mem_wkey),
    .mem_wtime    (mem_wtime),
    .mem_raddr    (mem_raddr),
    .mem_rkey     (mem_rkey),
    .mem_rtime    (mem_rtime),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_was_hit  (out_was_hit),
    .out_slot     (out_slot),
    .out_shares   (out_shares),
    .out_evicted  (out_evicted)
  );

endmodule

@@ tb/sv/stream_context_lru_idle_evict_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_context_lru_idle_evict_tb
// Self-checking bench for the stream context table. A behavioral copy of the
// table predicts every access and clear. Each strobed result is compared
// field by field with the oldest prediction. The run covers directed corner
// cases, then random traffic under several register settings, with bursty
// requests and random gaps.
// ----------------------------------------------------------------------------
module stream_context_lru_idle_evict_tb;

  localparam int NSLOT        = sclie_pkg::ENTRIES_DEF;
  localparam int KEY_POOL     = 12;
  localparam int SETTLE       = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_ITEMS   = 170;

  localparam int KEY_W      = sclie_pkg::KEY_W;
  localparam int NOW_W      = sclie_pkg::NOW_W;
  localparam int REG_W      = sclie_pkg::REG_W;
  localparam int MINS_W     = sclie_pkg::MINS_W;
  localparam int SLOT_W     = sclie_pkg::SLOT_W;
  localparam int CNT_OUT_W  = sclie_pkg::CNT_OUT_W;
  localparam int CFG_IDX_W  = sclie_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sclie_pkg::CFG_DATA_W;

  typedef struct packed {
    logic                 found;
    logic                 was_hit;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_OUT_W-1:0] shares;
    logic [CNT_OUT_W-1:0] evicted;
  } ctx_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_func;
  logic [KEY_W-1:0]      in_stream_id;
  logic [NOW_W-1:0]      in_now_ms;
  logic                  in_open_ok;
  logic                  out_valid;
  logic                  out_found;
  logic                  out_was_hit;
  logic [SLOT_W-1:0]     out_slot;
  logic [CNT_OUT_W-1:0]  out_shares;
  logic [CNT_OUT_W-1:0]  out_evicted;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow table and registers
  logic                  ctx_valid [NSLOT];
  logic [KEY_W-1:0]      ctx_key   [NSLOT];
  logic [NOW_W-1:0]      ctx_stamp [NSLOT];
  logic                  reg_path;
  logic [REG_W-1:0]      reg_evict;
  logic [REG_W-1:0]      reg_window;
  logic [MINS_W-1:0]     reg_min;

  ctx_result_t           pending_results [$];
  int                    mismatch_count;
  int                    quiet_cycles;
  logic [NOW_W-1:0]      clock_now;
  logic [KEY_W-1:0]      key_pool [KEY_POOL];

  stream_context_lru_idle_evict i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_stream_id (in_stream_id),
    .in_now_ms    (in_now_ms),
    .in_open_ok   (in_open_ok),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_was_hit  (out_was_hit),
    .out_slot     (out_slot),
    .out_shares   (out_shares),
    .out_evicted  (out_evicted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count live entries in the shadow table
  function automatic int live_count();
    int n;
    int s;
    n = 0;
    for (s = 0; s < NSLOT; s++)
      if (ctx_valid[s]) n++;
    return n;
  endfunction

  // Oldest live slot other than skip; NSLOT when none, ties to the lowest slot
  function automatic int oldest_slot(input logic [NOW_W-1:0] now, input int skip);
    int best;
    int s;
    logic [NOW_W-1:0] best_age;
    logic [NOW_W-1:0] age;
    best = NSLOT;
    best_age = '0;
    for (s = 0; s < NSLOT; s++) begin
      if (ctx_valid[s] && s != skip) begin
        age = now - ctx_stamp[s];
        if (best == NSLOT || age > best_age) begin
          best = s;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  // Apply one request to the shadow table and return the result it should give
  function automatic ctx_result_t predict_context(input logic func, input logic [KEY_W-1:0] id,
                                                  input logic [NOW_W-1:0] now, input logic ok);
    ctx_result_t r;
    int s;
    int cur;
    int dropped;
    int active;
    int size;
    int cap;
    int v;
    logic hit;
    logic [NOW_W-1:0] age;
    r = '0;
    cur = NSLOT;
    dropped = 0;
    active = 0;
    hit = 1'b0;
    if (func == sclie_pkg::FUNC_CLEAR) begin
      for (s = 0; s < NSLOT; s++) ctx_valid[s] = 1'b0;
      return r;
    end
    for (s = 0; s < NSLOT; s++) begin
      if (!hit && ctx_valid[s] && ctx_key[s] == id) begin
        cur = s;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      // Failed open leaves the table untouched
      if (!reg_path || !ok) begin
        r.shares = CNT_OUT_W'(live_count());
        return r;
      end
      for (s = 0; s < NSLOT; s++)
        if (cur == NSLOT && !ctx_valid[s]) cur = s;
      if (cur == NSLOT) begin
        cur = oldest_slot(now, NSLOT);
        dropped++;
      end
      ctx_valid[cur] = 1'b1;
      ctx_key[cur] = id;
    end
    ctx_stamp[cur] = now;
    // Idle sweep, the accessed entry is protected
    for (s = 0; s < NSLOT; s++) begin
      if (ctx_valid[s]) begin
        age = now - ctx_stamp[s];
        if (s != cur && age >= reg_evict) begin
          ctx_valid[s] = 1'b0;
          dropped++;
        end else if (age < reg_window) begin
          active++;
        end
      end
    end
    // Trim down to the cap
    cap = active + 1;
    if (int'(reg_min) > cap) cap = int'(reg_min);
    size = live_count();
    while (size > cap) begin
      v = oldest_slot(now, cur);
      if (v == NSLOT) break;
      ctx_valid[v] = 1'b0;
      dropped++;
      size--;
    end
    r.found = 1'b1;
    r.was_hit = hit;
    r.slot = SLOT_W'(cur);
    r.shares = CNT_OUT_W'(size);
    r.evicted = CNT_OUT_W'(dropped);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: check results, track register writes, predict accepted requests
  always @(posedge clk) begin
    ctx_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < NSLOT; s++) ctx_valid[s] = 1'b0;
      reg_path = sclie_pkg::PATH_SET_RST;
      reg_evict = sclie_pkg::IDLE_EVICT_RST;
      reg_window = sclie_pkg::ACTIVE_WIN_RST;
      reg_min = sclie_pkg::MIN_STREAMS_RST;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (out_valid) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending, found %0d slot %0d", $time,
                   out_found, out_slot);
        end else begin
          want = pending_results.pop_front();
          check_field("found", want.found, out_found);
          check_field("was_hit", want.was_hit, out_was_hit);
          check_field("slot", want.slot, out_slot);
          check_field("shares", want.shares, out_shares);
          check_field("evicted", want.evicted, out_evicted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          sclie_pkg::CFG_PATH_SET:    reg_path = cfg_data[0];
          sclie_pkg::CFG_IDLE_EVICT:  reg_evict = cfg_data;
          sclie_pkg::CFG_ACTIVE_WIN:  reg_window = cfg_data;
          sclie_pkg::CFG_MIN_STREAMS: reg_min = cfg_data[MINS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        pending_results.push_back(predict_context(in_func, in_stream_id, in_now_ms,
                                                  in_open_ok));
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic func, input logic [KEY_W-1:0] id,
                              input logic [NOW_W-1:0] now, input logic ok);
    start <= 1'b1;
    in_func <= func;
    in_stream_id <= id;
    in_now_ms <= now;
    in_open_ok <= ok;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load all four registers while the block is idle
  task automatic write_settings(input logic path, input logic [REG_W-1:0] evict,
                                input logic [REG_W-1:0] window, input logic [MINS_W-1:0] mins);
    drain_results();
    push_reg(sclie_pkg::CFG_PATH_SET, CFG_DATA_W'(path));
    push_reg(sclie_pkg::CFG_IDLE_EVICT, evict);
    push_reg(sclie_pkg::CFG_ACTIVE_WIN, window);
    push_reg(sclie_pkg::CFG_MIN_STREAMS, CFG_DATA_W'(mins));
    cfg_valid <= 1'b0;
  endtask

  // Time advance mixing no change, short, mid, past-eviction and wrapping steps
  function automatic logic [NOW_W-1:0] pick_step(input logic [REG_W-1:0] evict,
                                                 input logic [REG_W-1:0] window);
    int unsigned lo;
    int unsigned hi;
    lo = (evict < window) ? evict : window;
    hi = (evict < window) ? window : evict;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return $urandom_range(0, window);
      2: return $urandom_range(lo, hi);
      3: return evict + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Misses with no path configured fail; a clear on an empty table
  task automatic test_closed_path();
    send_request(sclie_pkg::FUNC_ACCESS, 64'h0123_4567_89ab_cdef, 32'd5, 1'b1);
    send_request(sclie_pkg::FUNC_CLEAR, '1, '1, 1'b1);
  endtask

  // Fill, replace, idle sweep, cap trim, wrap, clear and LRU ties
  task automatic test_table_corners();
    write_settings(1'b1, 32'd1000, 32'd100, 4'd2);
    send_request(sclie_pkg::FUNC_ACCESS, '0, 32'd0, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, '1, 32'd0, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, '0, 32'd10, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd5, 32'd12, 1'b0);
    for (int k = 2; k < 8; k++) send_request(sclie_pkg::FUNC_ACCESS, 64'(k), 32'd20, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd100, 32'd30, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, '0, 32'd300, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd3, 32'd1500, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd9, 32'hffff_fff0, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd9, 32'h0000_0010, 1'b1);
    send_request(sclie_pkg::FUNC_CLEAR, 64'd9, 32'h0000_0011, 1'b0);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd9, 32'h0000_0012, 1'b1);
    send_request(sclie_pkg::FUNC_CLEAR, '0, '0, 1'b1);
    for (int k = 20; k < 23; k++) send_request(sclie_pkg::FUNC_ACCESS, 64'(k), 32'h100, 1'b1);
    send_request(sclie_pkg::FUNC_ACCESS, 64'd23, 32'h200, 1'b1);
  endtask

  // Random bursty traffic over a small key pool under one register setting
  task automatic test_random_traffic(input int count, input logic path,
                                     input logic [REG_W-1:0] evict,
                                     input logic [REG_W-1:0] window,
                                     input logic [MINS_W-1:0] mins);
    int burst_left;
    int gap;
    logic func;
    logic [KEY_W-1:0] id;
    burst_left = 0;
    write_settings(path, evict, window, mins);
    for (int k = 0; k < KEY_POOL; k++) key_pool[k] = {$urandom, $urandom};
    for (int n = 0; n < count; n++) begin
      // hold off once mid-phase until the block has answered everything
      if (n == count / 2) drain_results();
      func = ($urandom_range(0, 99) < 3) ? sclie_pkg::FUNC_CLEAR : sclie_pkg::FUNC_ACCESS;
      if ($urandom_range(0, 99) < 85) id = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else id = {$urandom, $urandom};
      clock_now = clock_now + pick_step(evict, window);
      send_request(func, id, clock_now, $urandom_range(0, 9) != 0);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    clock_now = $urandom;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= sclie_pkg::FUNC_ACCESS;
    in_stream_id <= '0;
    in_now_ms <= '0;
    in_open_ok <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= sclie_pkg::CFG_PATH_SET;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_closed_path();
    test_table_corners();
    test_random_traffic(RAND_ITEMS, 1'b1, 32'd1000, 32'd100, 4'd2);
    test_random_traffic(RAND_ITEMS, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 4'd8);
    test_random_traffic(RAND_ITEMS, 1'b1, 32'd1, 32'd1, 4'd1);
    test_random_traffic(60, 1'b0, 32'd500, 32'd50, 4'd4);
    test_random_traffic(RAND_ITEMS, 1'b1, 32'd0, 32'd0, 4'd0);
    test_random_traffic(RAND_ITEMS, 1'b1, $urandom_range(1, 5000), $urandom_range(1, 5000),
                        MINS_W'($urandom_range(1, 8)));
    test_random_traffic(RAND_ITEMS, 1'b1, 32'd300, 32'd300, 4'd15);
    test_random_traffic(RAND_ITEMS, 1'b1, 32'd4000, 32'd30, 4'd3);
    drain_results();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
